@@ hw/rtl/hept_pkg.sv @@
// shared types, constants and microcode tables for the point-to-base transform
package hept_pkg;

	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	localparam logic [2:0] REG_ROW0    = 3'd0;
	localparam logic [2:0] REG_ROW1    = 3'd1;
	localparam logic [2:0] REG_ROW2    = 3'd2;
	localparam logic [2:0] REG_SHIFT_X = 3'd3;
	localparam logic [2:0] REG_SHIFT_Y = 3'd4;
	localparam logic [2:0] REG_SHIFT_Z = 3'd5;

	localparam logic signed [16:0] TURN_UNITS    = 17'sd23040;
	localparam logic signed [16:0] HALF_UNITS    = 17'sd11520;
	localparam logic signed [16:0] QUARTER_UNITS = 17'sd5760;
	localparam logic signed [31:0] CORDIC_X0     = 32'sd163008218;
	localparam logic [3:0]         CORDIC_LAST   = 4'd15;

	localparam logic [5:0] POSE_LAST  = 6'd50;
	localparam logic [5:0] POINT_LAST = 6'd8;

	typedef enum logic [3:0] {
		A_SA, A_CA, A_SB, A_CB, A_SG, A_CG, A_SACB, A_CACB, A_P, A_C
	} asel_t;

	typedef enum logic [3:0] {
		B_SA, B_CA, B_SB, B_CB, B_SG, B_CG, B_ONE, B_H, B_SHIFT, B_V
	} bsel_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_SACB, WB_CACB, WB_P, WB_C, WB_O, WB_W
	} wb_t;

	typedef struct packed {
		asel_t      asel;
		logic [3:0] aidx;
		bsel_t      bsel;
		logic [3:0] bidx;
		logic       clr;
		logic       neg;
		logic       sh;
		wb_t        wb;
		logic [3:0] widx;
	} uop_t;

	typedef struct packed {
		logic       accept;
		logic       cord_load;
		logic       cord_step;
		logic       cord_store;
		logic [1:0] ang_sel;
		logic [3:0] iter;
		uop_t       uop;
		logic       push;
	} dp_cmd_t;

	function automatic uop_t mk(asel_t a, int ai, bsel_t b, int bi,
			logic c, logic n, logic s, wb_t w, int wi);
		uop_t u;
		u.asel = a;
		u.aidx = 4'(ai);
		u.bsel = b;
		u.bidx = 4'(bi);
		u.clr  = c;
		u.neg  = n;
		u.sh   = s;
		u.wb   = w;
		u.widx = 4'(wi);
		return u;
	endfunction

	function automatic uop_t nop_uop();
		return mk(A_SA, 0, B_SA, 0, 1'b1, 1'b0, 1'b0, WB_NONE, 0);
	endfunction

	// pose program: trig products, P entries, then P*H and P*Th
	function automatic uop_t pose_uop(logic [5:0] n);
		uop_t u;
		u = nop_uop();
		case (n)
			6'd0:  u = mk(A_SA,   0, B_CB,  0, 1'b1, 1'b0, 1'b0, WB_SACB, 0);
			6'd1:  u = mk(A_CA,   0, B_CB,  0, 1'b1, 1'b0, 1'b0, WB_CACB, 0);
			6'd2:  u = mk(A_SA,   0, B_SB,  0, 1'b1, 1'b0, 1'b1, WB_P,    2);
			6'd3:  u = mk(A_CA,   0, B_CG,  0, 1'b1, 1'b0, 1'b1, WB_NONE, 0);
			6'd4:  u = mk(A_SACB, 0, B_SG,  0, 1'b0, 1'b1, 1'b0, WB_P,    0);
			6'd5:  u = mk(A_CA,   0, B_SG,  0, 1'b1, 1'b1, 1'b1, WB_NONE, 0);
			6'd6:  u = mk(A_SACB, 0, B_CG,  0, 1'b0, 1'b1, 1'b0, WB_P,    1);
			6'd7:  u = mk(A_SA,   0, B_CG,  0, 1'b1, 1'b0, 1'b1, WB_NONE, 0);
			6'd8:  u = mk(A_CACB, 0, B_SG,  0, 1'b0, 1'b0, 1'b0, WB_P,    3);
			6'd9:  u = mk(A_SA,   0, B_SG,  0, 1'b1, 1'b1, 1'b1, WB_NONE, 0);
			6'd10: u = mk(A_CACB, 0, B_CG,  0, 1'b0, 1'b0, 1'b0, WB_P,    4);
			6'd11: u = mk(A_CA,   0, B_SB,  0, 1'b1, 1'b1, 1'b1, WB_P,    5);
			6'd12: u = mk(A_SB,   0, B_SG,  0, 1'b1, 1'b0, 1'b1, WB_P,    6);
			6'd13: u = mk(A_SB,   0, B_CG,  0, 1'b1, 1'b0, 1'b1, WB_P,    7);
			6'd14: u = mk(A_CB,   0, B_ONE, 0, 1'b1, 1'b0, 1'b1, WB_P,    8);
			default: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						for (int k = 0; k < 3; k++)
							if (n == 6'(15 + i * 9 + j * 3 + k))
								u = mk(A_P, i * 3 + k, B_H, k * 3 + j, k == 0, 1'b0,
									1'b0, (k == 2) ? WB_C : WB_NONE, i * 3 + j);
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						if (n == 6'(42 + i * 3 + j))
							u = mk(A_P, i * 3 + j, B_SHIFT, j, j == 0, 1'b0, 1'b0,
								(j == 2) ? WB_O : WB_NONE, i);
			end
		endcase
		return u;
	endfunction

	function automatic uop_t point_uop(logic [5:0] n);
		uop_t u;
		u = nop_uop();
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (n == 6'(i * 3 + j))
					u = mk(A_C, i * 3 + j, B_V, j, j == 0, 1'b0, 1'b0,
						(j == 2) ? WB_W : WB_NONE, i);
		return u;
	endfunction

	// arctangent steps in 2^-14 degree
	function automatic logic [20:0] atan_of(logic [3:0] i);
		logic [20:0] r;
		case (i)
			4'd0:    r = 21'd737280;
			4'd1:    r = 21'd435243;
			4'd2:    r = 21'd229971;
			4'd3:    r = 21'd116736;
			4'd4:    r = 21'd58595;
			4'd5:    r = 21'd29326;
			4'd6:    r = 21'd14667;
			4'd7:    r = 21'd7334;
			4'd8:    r = 21'd3667;
			4'd9:    r = 21'd1833;
			4'd10:   r = 21'd917;
			4'd11:   r = 21'd458;
			4'd12:   r = 21'd229;
			4'd13:   r = 21'd115;
			4'd14:   r = 21'd57;
			default: r = 21'd29;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [47:0] v);
		if (v > 48'sd32767)
			return 16'sh7fff;
		if (v < -48'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(logic signed [47:0] v);
		if (v > 48'sd8388607)
			return 24'sh7fffff;
		if (v < -48'sd8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [47:0] v);
		if (v > 48'sd2147483647)
			return 32'sh7fffffff;
		if (v < -48'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

@@ hw/rtl/hept_ctrl.sv @@
// sequencer: cordic runs, microcode stepping and output word handshake
module hept_ctrl
	import hept_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_point,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLOAD, ST_CRUN, ST_CSTORE, ST_PROG, ST_DRAIN, ST_PUSH
	} state_t;

	state_t     state_q;
	logic [1:0] ang_q;
	logic [3:0] iter_q;
	logic [5:0] step_q;
	logic       drain_q;
	logic       point_q;
	logic       out_valid_q;
	logic       accept;
	logic       push;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign push      = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.cord_load  = (state_q == ST_CLOAD);
		cmd.cord_step  = (state_q == ST_CRUN);
		cmd.cord_store = (state_q == ST_CSTORE);
		cmd.ang_sel    = ang_q;
		cmd.iter       = iter_q;
		cmd.push       = push;
		if (state_q == ST_PROG)
			cmd.uop = point_q ? point_uop(step_q) : pose_uop(step_q);
		else
			cmd.uop = nop_uop();
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ang_q       <= '0;
			iter_q      <= '0;
			step_q      <= '0;
			drain_q     <= 1'b0;
			point_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						point_q <= in_point;
						step_q  <= '0;
						ang_q   <= '0;
						state_q <= in_point ? ST_PROG : ST_CLOAD;
					end
				end
				ST_CLOAD: begin
					iter_q  <= '0;
					state_q <= ST_CRUN;
				end
				ST_CRUN: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == CORDIC_LAST)
						state_q <= ST_CSTORE;
				end
				ST_CSTORE: begin
					if (ang_q == 2'd2) begin
						state_q <= ST_PROG;
					end else begin
						ang_q   <= ang_q + 2'd1;
						state_q <= ST_CLOAD;
					end
				end
				ST_PROG: begin
					step_q <= step_q + 6'd1;
					if (step_q == (point_q ? POINT_LAST : POSE_LAST)) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// mac pipeline is two deep behind the last issue
					drain_q <= 1'b1;
					if (drain_q)
						state_q <= point_q ? ST_PUSH : ST_IDLE;
				end
				ST_PUSH: begin
					if (push)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/hept_dp.sv @@
// datapath: config registers, cordic unit, shared multiply-accumulate, result store
module hept_dp
	import hept_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [119:0]       in_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [APB_DW-1:0]  cfg_wdata,
	output logic [APB_DW-1:0]  cfg_rdata,
	output logic [71:0]        out_data
);

	logic        [47:0] h_row_q   [3];
	logic signed [23:0] shift_q   [3];
	logic signed [15:0] h_flat    [9];
	logic signed [23:0] coord_q   [3];
	logic signed [15:0] ang_q     [3];
	logic signed [15:0] sa_q, ca_q, sb_q, cb_q, sg_q, cg_q;
	logic signed [31:0] sacb_q, cacb_q;
	logic signed [15:0] p_q       [9];
	logic signed [15:0] crot_q    [9];
	logic signed [31:0] coff_q    [3];
	logic signed [23:0] world_q   [3];
	logic        [71:0] out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_row_q[0] <= 48'd16384;
			h_row_q[1] <= 48'd16384 << 16;
			h_row_q[2] <= 48'd16384 << 32;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROW0:    h_row_q[0] <= cfg_wdata[47:0];
				REG_ROW1:    h_row_q[1] <= cfg_wdata[47:0];
				REG_ROW2:    h_row_q[2] <= cfg_wdata[47:0];
				REG_SHIFT_X: shift_q[0] <= cfg_wdata[23:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_wdata[23:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ROW0:    cfg_rdata = {16'd0, h_row_q[0]};
			REG_ROW1:    cfg_rdata = {16'd0, h_row_q[1]};
			REG_ROW2:    cfg_rdata = {16'd0, h_row_q[2]};
			REG_SHIFT_X: cfg_rdata = {40'd0, shift_q[0]};
			REG_SHIFT_Y: cfg_rdata = {40'd0, shift_q[1]};
			REG_SHIFT_Z: cfg_rdata = {40'd0, shift_q[2]};
			default:     cfg_rdata = '0;
		endcase
	end

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				h_flat[r * 3 + c] = h_row_q[r][16 * c +: 16];
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			coord_q[0] <= in_data[23:0];
			coord_q[1] <= in_data[47:24];
			coord_q[2] <= in_data[71:48];
			ang_q[0]   <= in_data[87:72];
			ang_q[1]   <= in_data[103:88];
			ang_q[2]   <= in_data[119:104];
		end
	end

	// cordic: one micro-rotation per cycle
	logic signed [16:0] r0, r1, r2;
	logic               fold_neg;
	logic signed [31:0] cx_q, cy_q, dx, dy, xr, yr;
	logic signed [23:0] cz_q, atan_v;
	logic               cneg_q;
	logic signed [15:0] cos_v, sin_v;

	always_comb begin
		r0 = 17'(ang_q[cmd.ang_sel]);
		if (r0 >= HALF_UNITS)
			r1 = r0 - TURN_UNITS;
		else if (r0 < -HALF_UNITS)
			r1 = r0 + TURN_UNITS;
		else
			r1 = r0;
		fold_neg = 1'b1;
		if (r1 > QUARTER_UNITS)
			r2 = r1 - HALF_UNITS;
		else if (r1 < -QUARTER_UNITS)
			r2 = r1 + HALF_UNITS;
		else begin
			r2       = r1;
			fold_neg = 1'b0;
		end
		dx     = cy_q >>> cmd.iter;
		dy     = cx_q >>> cmd.iter;
		atan_v = 24'(atan_of(cmd.iter));
		xr     = (cx_q + 32'sd8192) >>> 14;
		yr     = (cy_q + 32'sd8192) >>> 14;
		if (xr > 32'sd16384)
			cos_v = 16'sd16384;
		else if (xr < -32'sd16384)
			cos_v = -16'sd16384;
		else
			cos_v = xr[15:0];
		if (yr > 32'sd16384)
			sin_v = 16'sd16384;
		else if (yr < -32'sd16384)
			sin_v = -16'sd16384;
		else
			sin_v = yr[15:0];
		if (cneg_q) begin
			cos_v = -cos_v;
			sin_v = -sin_v;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cord_load) begin
			cx_q   <= CORDIC_X0;
			cy_q   <= '0;
			cz_q   <= 24'(r2) <<< 8;
			cneg_q <= fold_neg;
		end else if (cmd.cord_step) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + atan_v;
			end
		end
		if (cmd.cord_store) begin
			case (cmd.ang_sel)
				2'd0: begin
					sa_q <= sin_v;
					ca_q <= cos_v;
				end
				2'd1: begin
					sb_q <= sin_v;
					cb_q <= cos_v;
				end
				default: begin
					sg_q <= sin_v;
					cg_q <= cos_v;
				end
			endcase
		end
	end

	// shared mac: operand select, product register, accumulator, write-back
	logic signed [31:0] a_op;
	logic signed [23:0] b_op;
	logic signed [55:0] prod_full;
	logic signed [47:0] prod_s1, acc_s2, term, r14, r28;
	uop_t               ctl_s1, ctl_s2;

	always_comb begin
		case (cmd.uop.asel)
			A_SA:    a_op = 32'(sa_q);
			A_CA:    a_op = 32'(ca_q);
			A_SB:    a_op = 32'(sb_q);
			A_CB:    a_op = 32'(cb_q);
			A_SG:    a_op = 32'(sg_q);
			A_CG:    a_op = 32'(cg_q);
			A_SACB:  a_op = sacb_q;
			A_CACB:  a_op = cacb_q;
			A_P:     a_op = 32'(p_q[cmd.uop.aidx]);
			A_C:     a_op = 32'(crot_q[cmd.uop.aidx]);
			default: a_op = '0;
		endcase
		case (cmd.uop.bsel)
			B_SA:    b_op = 24'(sa_q);
			B_CA:    b_op = 24'(ca_q);
			B_SB:    b_op = 24'(sb_q);
			B_CB:    b_op = 24'(cb_q);
			B_SG:    b_op = 24'(sg_q);
			B_CG:    b_op = 24'(cg_q);
			B_ONE:   b_op = 24'sd16384;
			B_H:     b_op = 24'(h_flat[cmd.uop.bidx]);
			B_SHIFT: b_op = shift_q[cmd.uop.bidx[1:0]];
			B_V:     b_op = coord_q[cmd.uop.bidx[1:0]];
			default: b_op = '0;
		endcase
		prod_full = a_op * b_op;
		term      = ctl_s1.sh ? (prod_s1 <<< 14) : prod_s1;
		if (ctl_s1.neg)
			term = -term;
		r14 = (acc_s2 + 48'sd8192) >>> 14;
		r28 = (acc_s2 + 48'sd134217728) >>> 28;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= nop_uop();
			ctl_s2 <= nop_uop();
		end else begin
			ctl_s1 <= cmd.uop;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[47:0];
		acc_s2  <= (ctl_s1.clr ? 48'sd0 : acc_s2) + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				crot_q[i] <= (i % 4 == 0) ? 16'sd16384 : 16'sd0;
			for (int i = 0; i < 3; i++)
				coff_q[i] <= '0;
		end else begin
			case (ctl_s2.wb)
				WB_C:    crot_q[ctl_s2.widx] <= sat16(r14);
				WB_O:    coff_q[ctl_s2.widx[1:0]] <=
					sat32(r14 + 48'(coord_q[ctl_s2.widx[1:0]]));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl_s2.wb)
			WB_SACB: sacb_q <= acc_s2[31:0];
			WB_CACB: cacb_q <= acc_s2[31:0];
			WB_P:    p_q[ctl_s2.widx] <= sat16(r28);
			WB_W:    world_q[ctl_s2.widx[1:0]] <=
				sat24(r14 + 48'(coff_q[ctl_s2.widx[1:0]]));
			default: ;
		endcase
		if (cmd.push)
			out_q <= {world_q[2], world_q[1], world_q[0]};
	end

	assign out_data = out_q;

endmodule

@@ hw/rtl/hand_eye_point_to_base_transform.sv @@
// top level of the hand-eye point-to-base transform
//
// Input stream s_axis: tuser 0 is a pose word (arm translation and ZXZ
// angles), tuser 1 a camera point. Output stream m_axis carries one base-frame
// point for each camera point; pose words give no output.
// The APB port holds the hand-eye rotation rows and translation (byte
// address 8*i, 64-bit data); write it only while the block is idle.
// A point runs nine multiply-accumulates through the single shared 32x24
// multiplier, a drain of the mac pipeline and one output load; output valid
// rises in the same cycle that the block is idle again for the next word.
// A pose keeps the block busy through three 16-step CORDIC runs, each with a
// load and a store step, 51 steps of the shared multiplier and a pipeline drain.
// One word is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new word is accepted while an
// earlier result waits on m_axis_tready; a further point holds in its output
// load step until the register is free.
// Reset restores the identity hand-eye matrix, zero translation and an
// identity stored transform, with no output pending.
module hand_eye_point_to_base_transform
	import hept_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [119:0]      s_axis_tdata,  // coord_x, coord_y, coord_z, angle_first, angle_second, angle_third
	input  logic              s_axis_tuser,  // req_type
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [71:0]       m_axis_tdata,  // world_x, world_y, world_z
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	dp_cmd_t cmd;
	logic    cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	hept_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_point  (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	hept_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (paddr[5:3]),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata),
		.out_data  (m_axis_tdata)
	);

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// a pose word never raises an output
	a_pose_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !$rose(m_axis_tvalid))
		else $error("pose word produced output");

	// output load and input acceptance never coincide
	a_push_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !cmd.accept)
		else $error("output loaded while accepting input");

endmodule

@@ sim/hept_checker.sv @@
// checker for the point-to-base transform: predicts world points and compares them
`timescale 1ns / 100ps

module hept_checker
	import hept_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [71:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic signed [23:0] z;
		logic signed [23:0] y;
		logic signed [23:0] x;
	} world_pt_t;

	logic [47:0]        he_row [3];
	longint             he_shift [3];
	longint             comb_rot [9];
	longint             comb_off [3];
	world_pt_t          expected_points [$];

	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic trig(input longint a, output longint s, output longint c);
		longint r, x, y, z, dx, dy;
		longint atans [16];
		bit flip;
		atans = '{737280, 435243, 229971, 116736, 58595, 29326, 14667, 7334,
			3667, 1833, 917, 458, 229, 115, 57, 29};
		r = ((a % 23040) + 23040) % 23040;
		flip = 0;
		if (r >= 11520)
			r -= 23040;
		if (r > 5760) begin
			r -= 11520;
			flip = 1;
		end else if (r < -5760) begin
			r += 11520;
			flip = 1;
		end
		x = 163008218;
		y = 0;
		z = r * 256;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atans[i];
			end else begin
				x += dx; y -= dy; z += atans[i];
			end
		end
		x = clip(round_shift(x, 14), -16384, 16384);
		y = clip(round_shift(y, 14), -16384, 16384);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint q42(longint v);
		return clip(round_shift(v, 28), -32768, 32767);
	endfunction

	task automatic load_pose(input longint t[3], input longint a, input longint b,
			input longint g);
		longint sa, ca, sb, cb, sg, cg, acc, d;
		longint p [9];
		longint h [9];
		longint one;
		one = 16384;
		trig(a, sa, ca);
		trig(b, sb, cb);
		trig(g, sg, cg);
		p[0] = q42(ca * cg * one - sa * cb * sg);
		p[1] = q42(-ca * sg * one - sa * cb * cg);
		p[2] = q42(sa * sb * one);
		p[3] = q42(sa * cg * one + ca * cb * sg);
		p[4] = q42(-sa * sg * one + ca * cb * cg);
		p[5] = q42(-ca * sb * one);
		p[6] = q42(sb * sg * one);
		p[7] = q42(sb * cg * one);
		p[8] = q42(cb * one * one);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				h[i * 3 + j] = longint'($signed(he_row[i][16 * j +: 16]));
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				d = 0;
				for (int k = 0; k < 3; k++)
					d += p[i * 3 + k] * h[k * 3 + j];
				comb_rot[i * 3 + j] = clip(round_shift(d, 14), -32768, 32767);
				acc += p[i * 3 + j] * he_shift[j];
			end
			comb_off[i] = clip(round_shift(acc, 14) + t[i], -64'sd2147483648,
				64'sd2147483647);
		end
	endtask

	function automatic world_pt_t map_point(longint v[3]);
		world_pt_t w;
		longint acc, r [3];
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += comb_rot[i * 3 + j] * v[j];
			r[i] = clip(round_shift(acc, 14) + comb_off[i], -8388608, 8388607);
		end
		w.x = r[0][23:0];
		w.y = r[1][23:0];
		w.z = r[2][23:0];
		return w;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	assign pending = expected_points.size();

	initial begin
		fail_count = 0;
		he_row[0] = 48'd16384;
		he_row[1] = 48'd16384 << 16;
		he_row[2] = 48'd16384 << 32;
		for (int i = 0; i < 3; i++) begin
			he_shift[i] = 0;
			comb_off[i] = 0;
		end
		for (int i = 0; i < 9; i++)
			comb_rot[i] = (i % 4 == 0) ? 16384 : 0;
	end

	always @(posedge clk) begin
		longint v [3];
		world_pt_t got, want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_ROW0, REG_ROW1, REG_ROW2:
						he_row[paddr[4:3]] = pwdata[47:0];
					REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z:
						he_shift[paddr[5:3] - REG_SHIFT_X] =
							longint'($signed(pwdata[23:0]));
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				for (int i = 0; i < 3; i++)
					v[i] = longint'($signed(s_axis_tdata[24 * i +: 24]));
				if (!s_axis_tuser)
					load_pose(v, longint'($signed(s_axis_tdata[72 +: 16])),
						longint'($signed(s_axis_tdata[88 +: 16])),
						longint'($signed(s_axis_tdata[104 +: 16])));
				else
					expected_points.insert(expected_points.size(), map_point(v));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_points.size() == 0) begin
					$display("unexpected world point at %0t", $time);
					fail_count++;
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x) report("world_x", got.x, want.x);
					if (got.y !== want.y) report("world_y", got.y, want.y);
					if (got.z !== want.z) report("world_z", got.z, want.z);
				end
			end
		end
	end

endmodule

@@ sim/tb_hand_eye_point_to_base_transform.sv @@
// testbench top: stimulus, hand-eye register settings and verdict
`timescale 1ns / 100ps

module tb_hand_eye_point_to_base_transform;
	import hept_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [119:0]      s_axis_tdata;
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [71:0]       m_axis_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	bit                rx_quiet;

	hand_eye_point_to_base_transform u_top (.*);

	hept_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 120);
	endfunction

	// result side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_quiet || $urandom_range(0, 9) < 6) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= gap_len() == 0;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		// a pose still in work gives no result to wait for
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_q14();
		case ($urandom_range(0, 5))
			0: return 16'h4000;
			1: return 16'hc000;
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 4095)) - 24'd2048;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 16'sd23040;
			1: return -16'sd23040;
			2: return 16'($urandom);
			3: return 16'(5760 * $signed($urandom_range(0, 8)) - 23040);
			default: return 16'($signed($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	task automatic send(input logic kind, input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z, input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] g);
		// valid stays low for a random gap, never empty, after the previous word
		repeat (1 + gap_len()) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {g, b, a, z, y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic rand_item(input int pose_pct);
		logic [15:0] a;
		a = rand_angle();
		if ($urandom_range(0, 99) < pose_pct)
			send(1'b0, rand_coord(), rand_coord(), rand_coord(), a, rand_angle(),
				rand_angle());
		else
			send(1'b1, rand_coord(), rand_coord(), rand_coord(), a, rand_angle(),
				rand_angle());
	endtask

	task automatic rand_config(input bit extreme);
		for (int i = 0; i < 3; i++)
			reg_write(3'(i), extreme ? {16'hffff, 16'h7fff, 16'h8000, 16'h7fff}
				: {16'($urandom), rand_q14(), rand_q14(), rand_q14()});
		for (int i = 0; i < 3; i++)
			reg_write(3'(REG_SHIFT_X + i), extreme ? (i[0] ? 64'hffffff800000
				: 64'h7fffff) : {40'($urandom), rand_coord()});
	endtask

	initial begin
		arst_n = 1'b0;
		rx_quiet = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity transform after reset, then field extremes
		send(1'b1, 24'h7fffff, 24'h800000, 24'h000001, 16'd0, 16'd0, 16'd0);
		send(1'b1, 24'h800000, 24'h7fffff, 24'hffffff, 16'd0, 16'd0, 16'd0);
		send(1'b0, 24'h000100, 24'hffff00, 24'h7fffff, 16'sd90, 16'sd45, 16'sd30);
		send(1'b1, 24'h7fffff, 24'h7fffff, 24'h7fffff, 16'd0, 16'd0, 16'd0);
		send(1'b0, 24'h0, 24'h0, 24'h0, 16'sd23040, -16'sd23040, 16'sd11520);
		send(1'b1, 24'h012345, 24'hfedcba, 24'h000400, 16'd0, 16'd0, 16'd0);
		send(1'b0, 24'h0, 24'h0, 24'h0, 16'sd5760, -16'sd5760, 16'sd5761);
		send(1'b1, 24'h001000, 24'h002000, 24'h003000, 16'hffff, 16'hffff, 16'hffff);
		// angles wrap beyond a full turn
		send(1'b0, 24'h800000, 24'h7fffff, 24'h0, 16'h7fff, 16'h8000, -16'sd11520);
		send(1'b1, 24'h800000, 24'h800000, 24'h800000, 16'd0, 16'd0, 16'd0);
		send(1'b0, 24'h0, 24'h0, 24'h0, 16'sd11519, -16'sd11521, 16'sd17280);
		send(1'b1, 24'h00abcd, 24'hff1234, 24'h070000, 16'd0, 16'd0, 16'd0);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			rand_config(phase == 1);
			if (phase == 3) begin
				reg_write(REG_ROW0, 64'h0);
				reg_write(REG_ROW1, 64'h0);
				reg_write(REG_ROW2, 64'h0);
			end
			rx_quiet = (phase == 5);
			for (int n = 0; n < 210; n++) begin
				rand_item(20);
				if (n == 100) begin
					// hold off until every point is back
					while (pending != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
